>>> rtl/pvp_pkg.sv
package pvp_pkg;

  localparam int NUM_W = 63;
  localparam int DEN_W = 32;
  localparam int DIV_N = NUM_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 31;

  localparam logic [NUM_W-1:0] BIG_MAG = {2'b10, {(NUM_W-2){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 3'd0,
    CFG_DIST   = 3'd1,
    CFG_ASPECT = 3'd2,
    CFG_WIDTH  = 3'd3,
    CFG_HEIGHT = 3'd4
  } pvp_cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_PERSP = 2'd0,
    MODE_VIEW  = 2'd1,
    MODE_CAM   = 2'd2,
    MODE_HDIV  = 2'd3
  } pvp_mode_t;

  typedef struct packed {
    logic               valid;
    logic               skip;
    logic               last;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
    logic signed [63:0] rx1;
    logic signed [63:0] ry1;
    logic [2:0]         qneg;
    logic [2:0]         nneg;
    logic               dz;
  } pvp_side_t;

  // saturate to signed 32 bits; bit 32 flags a clip
  function automatic logic [32:0] sat32(input logic signed [63:0] v);
    logic [32:0] r;
    if (v > 64'sh7FFF_FFFF) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -64'sh8000_0000) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

>>> rtl/pvp_if.sv
interface pvp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_in;
  logic signed [31:0] y_in;
  logic signed [31:0] z_in;
  logic signed [31:0] w_in;
  logic               poly_skip;
  logic               last_vertex;
  modport source (output valid, x_in, y_in, z_in, w_in, poly_skip, last_vertex, input ready);
  modport sink (input valid, x_in, y_in, z_in, w_in, poly_skip, last_vertex, output ready);
endinterface

interface pvp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_out;
  logic signed [31:0] y_out;
  logic signed [31:0] z_out;
  logic signed [31:0] w_out;
  logic               divide_fault;
  logic               last_out;
  modport source (output valid, x_out, y_out, z_out, w_out, divide_fault, last_out,
                  input ready);
  modport sink (input valid, x_out, y_out, z_out, w_out, divide_fault, last_out,
                output ready);
endinterface

>>> rtl/perspective_viewport_projection_unit.sv
// Pipeline: capture, operand and sign stages ahead of a 63-stage restoring divider,
// one quotient bit per stage, then the quotient stage and the output register.
// Throughput: one vertex per cycle; the whole pipeline holds while the output
// register is full and not taken.
// Reset: synchronous active-low rst_n clears all valid bits and loads the
// configuration defaults (mode 2, d 1.0, aspect 1.0, 640 x 480).
module perspective_viewport_projection_unit import pvp_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pvp_in_if.sink                in_ch,
  pvp_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRAC_BITS;

  // configuration
  pvp_mode_t   mode_r;
  logic [30:0] dist_r;
  logic [30:0] asp_r;
  logic [12:0] vw_r;
  logic [12:0] vh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_CAM;
      dist_r <= 31'd65536;
      asp_r  <= 31'd65536;
      vw_r   <= 13'd640;
      vh_r   <= 13'd480;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:   mode_r <= pvp_mode_t'(cfg_data[1:0]);
        CFG_DIST:   dist_r <= cfg_data;
        CFG_ASPECT: asp_r  <= cfg_data;
        CFG_WIDTH:  vw_r   <= cfg_data[12:0];
        CFG_HEIGHT: vh_r   <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_r;
  assign en = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  logic signed [13:0] wm1, hm1;
  assign wm1 = $signed({1'b0, vw_r}) - 14'sd1;
  assign hm1 = $signed({1'b0, vh_r}) - 14'sd1;

  // stage A: capture request
  logic               a_valid_r, a_skip_r, a_last_r;
  logic signed [31:0] a_x_r, a_y_r, a_z_r, a_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_x_r    <= in_ch.x_in;
      a_y_r    <= in_ch.y_in;
      a_z_r    <= in_ch.z_in;
      a_w_r    <= in_ch.w_in;
      a_skip_r <= in_ch.poly_skip;
      a_last_r <= in_ch.last_vertex;
    end
  end

  // stage B: numerators, divisor, viewport products
  logic signed [31:0] d_s;
  assign d_s = $signed({1'b0, dist_r});

  logic               b_valid_r, b_skip_r, b_last_r;
  logic signed [31:0] b_x_r, b_y_r, b_z_r, b_w_r, b_den_r;
  logic signed [63:0] b_num_r [3];
  logic signed [45:0] b_pmx_r, b_pmy_r;

  logic signed [63:0] nx_nxt, ny_nxt, nz_nxt;
  logic signed [31:0] den_nxt;
  logic signed [45:0] pmx_nxt, pmy_nxt;

  always_comb begin
    if (mode_r == MODE_HDIV) begin
      nx_nxt  = 64'(a_x_r) <<< FRAC_BITS;
      ny_nxt  = 64'(a_y_r) <<< FRAC_BITS;
      nz_nxt  = 64'(a_z_r) <<< FRAC_BITS;
      den_nxt = a_w_r;
    end else begin
      nx_nxt  = d_s * a_x_r;
      ny_nxt  = d_s * a_y_r;
      nz_nxt  = '0;
      den_nxt = a_z_r;
    end
    pmx_nxt = wm1 * a_x_r;
    pmy_nxt = hm1 * a_y_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_x_r      <= a_x_r;
      b_y_r      <= a_y_r;
      b_z_r      <= a_z_r;
      b_w_r      <= a_w_r;
      b_skip_r   <= a_skip_r;
      b_last_r   <= a_last_r;
      b_num_r[0] <= nx_nxt;
      b_num_r[1] <= ny_nxt;
      b_num_r[2] <= nz_nxt;
      b_den_r    <= den_nxt;
      b_pmx_r    <= pmx_nxt;
      b_pmy_r    <= pmy_nxt;
    end
  end

  // stage C: magnitudes and signs, finish viewport mapping
  pvp_side_t        c_side_r;
  logic [NUM_W-1:0] c_mag_r [3];
  logic [DEN_W-1:0] c_dm_r;

  pvp_side_t        side_nxt;
  logic [NUM_W-1:0] mag_nxt [3];
  logic [DEN_W-1:0] dm_nxt;
  logic signed [63:0] negn, hx, hy;

  always_comb begin
    side_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      negn = -b_num_r[i];
      mag_nxt[i] = b_num_r[i][63] ? negn[NUM_W-1:0] : b_num_r[i][NUM_W-1:0];
      side_nxt.nneg[i] = b_num_r[i][63];
      side_nxt.qneg[i] = b_num_r[i][63] ^ b_den_r[31];
    end
    dm_nxt = b_den_r[31] ? DEN_W'(-b_den_r) : DEN_W'(b_den_r);
    // halve toward zero
    hx = (64'(b_pmx_r) + $signed({63'd0, b_pmx_r[45]})) >>> 1;
    hy = (64'(b_pmy_r) + $signed({63'd0, b_pmy_r[45]})) >>> 1;
    side_nxt.valid = b_valid_r;
    side_nxt.skip  = b_skip_r;
    side_nxt.last  = b_last_r;
    side_nxt.x     = b_x_r;
    side_nxt.y     = b_y_r;
    side_nxt.z     = b_z_r;
    side_nxt.w     = b_w_r;
    side_nxt.dz    = (b_den_r == '0);
    side_nxt.rx1   = (64'(wm1) <<< (FRAC_BITS - 1)) + hx;
    side_nxt.ry1   = (64'(hm1) <<< (FRAC_BITS - 1)) - hy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_side_r.valid <= 1'b0;
    end else if (en) begin
      c_side_r.valid <= side_nxt.valid;
    end
    if (en) begin
      c_side_r[$bits(pvp_side_t)-2:0] <= side_nxt[$bits(pvp_side_t)-2:0];
      c_mag_r <= mag_nxt;
      c_dm_r  <= dm_nxt;
    end
  end

  // divider lanes with the side info traveling alongside
  logic [NUM_W-1:0] quo [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    pvp_divider u_div (
      .clk (clk),
      .en  (en),
      .num (c_mag_r[i]),
      .den (c_dm_r),
      .quo (quo[i])
    );
  end

  pvp_side_t sd_r [DIV_N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_N; k++) sd_r[k].valid <= 1'b0;
    end else if (en) begin
      sd_r[0].valid <= c_side_r.valid;
      for (int k = 1; k < DIV_N; k++) sd_r[k].valid <= sd_r[k-1].valid;
    end
    if (en) begin
      sd_r[0][$bits(pvp_side_t)-2:0] <= c_side_r[$bits(pvp_side_t)-2:0];
      for (int k = 1; k < DIV_N; k++) begin
        sd_r[k][$bits(pvp_side_t)-2:0] <= sd_r[k-1][$bits(pvp_side_t)-2:0];
      end
    end
  end

  // stage E: signed quotients, aspect partial products
  pvp_side_t          e_side_r;
  logic signed [63:0] e_q_r [3];
  logic [61:0]        e_phi_r;
  logic [62:0]        e_plo_r;
  logic               e_yneg_r;

  pvp_side_t          s_last;
  logic [NUM_W-1:0]   qm [3];
  logic               qn [3];
  logic signed [63:0] sq [3];

  assign s_last = sd_r[DIV_N-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qm[i] = s_last.dz ? BIG_MAG : quo[i];
      qn[i] = s_last.dz ? s_last.nneg[i] : s_last.qneg[i];
      sq[i] = qn[i] ? -$signed({1'b0, qm[i]}) : $signed({1'b0, qm[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_side_r.valid <= 1'b0;
    end else if (en) begin
      e_side_r.valid <= s_last.valid;
    end
    if (en) begin
      e_side_r[$bits(pvp_side_t)-2:0] <= s_last[$bits(pvp_side_t)-2:0];
      e_q_r    <= sq;
      e_phi_r  <= qm[1][62:32] * asp_r;
      e_plo_r  <= qm[1][31:0] * asp_r;
      e_yneg_r <= qn[1];
    end
  end

  // stage F: combine per mode, saturate, output register
  logic [63:0]        mf_mag;
  logic signed [63:0] mf;
  logic signed [63:0] rx, ry, rz, rw;
  logic [32:0]        sx, sy, sz, sw;
  logic               div_flt;

  always_comb begin
    if (e_phi_r > 62'(64'd1 << FRAC_BITS)) begin
      mf_mag = 64'(BIG_MAG);
    end else begin
      mf_mag = (64'(e_phi_r) << (32 - FRAC_BITS)) + (64'(e_plo_r) >> FRAC_BITS);
    end
    mf = e_yneg_r ? -$signed(mf_mag) : $signed(mf_mag);

    rx = 64'(e_side_r.x);
    ry = 64'(e_side_r.y);
    rz = 64'(e_side_r.z);
    rw = 64'(e_side_r.w);
    div_flt = 1'b0;
    if (!e_side_r.skip) begin
      case (mode_r)
        MODE_PERSP: begin
          rx = e_q_r[0];
          ry = mf;
          div_flt = e_side_r.dz;
        end
        MODE_VIEW: begin
          rx = e_side_r.rx1;
          ry = e_side_r.ry1;
        end
        MODE_CAM: begin
          rx = e_q_r[0] + (64'(wm1) <<< (FRAC_BITS - 1));
          ry = (64'(hm1) <<< (FRAC_BITS - 1)) - e_q_r[1];
          rw = ONE_Q;
          div_flt = e_side_r.dz;
        end
        MODE_HDIV: begin
          rx = e_q_r[0];
          ry = e_q_r[1];
          rz = e_q_r[2];
          div_flt = e_side_r.dz;
        end
        default: ;
      endcase
    end
    sx = sat32(rx);
    sy = sat32(ry);
    sz = sat32(rz);
    sw = sat32(rw);
  end

  logic signed [31:0] out_x_r, out_y_r, out_z_r, out_w_r;
  logic               out_fault_r, out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= e_side_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x_r     <= sx[31:0];
      out_y_r     <= sy[31:0];
      out_z_r     <= sz[31:0];
      out_w_r     <= sw[31:0];
      out_fault_r <= div_flt | sx[32] | sy[32] | sz[32] | sw[32];
      out_last_r  <= e_side_r.last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.x_out        = out_x_r;
  assign out_ch.y_out        = out_y_r;
  assign out_ch.z_out        = out_z_r;
  assign out_ch.w_out        = out_w_r;
  assign out_ch.divide_fault = out_fault_r;
  assign out_ch.last_out     = out_last_r;

`ifndef NO_ASSERTIONS
  a_rst_clears: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("output valid after reset");
  a_div_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    sd_r[DIV_N-1].valid && en |=> e_side_r.valid)
    else $error("request lost leaving divider");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en && sd_r[0].valid |=> sd_r[0].valid)
    else $error("divider request dropped during stall");
  a_skip_clean: assert property (@(posedge clk) disable iff (!rst_n)
    en && e_side_r.valid && e_side_r.skip |=> !out_fault_r)
    else $error("skip fault");
`endif

endmodule

>>> rtl/pvp_divider.sv
module pvp_divider import pvp_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);

  logic [DEN_W-1:0] rem_r [DIV_N];
  logic [NUM_W-1:0] nq_r  [DIV_N];
  logic [DEN_W-1:0] den_r [DIV_N];

  for (genvar k = 0; k < DIV_N; k++) begin : g_stage
    logic [DEN_W-1:0] rem_i;
    logic [NUM_W-1:0] nq_i;
    logic [DEN_W-1:0] den_i;
    logic [DEN_W:0]   t;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_i = '0;
      assign nq_i  = num;
      assign den_i = den;
    end else begin : g_next
      assign rem_i = rem_r[k-1];
      assign nq_i  = nq_r[k-1];
      assign den_i = den_r[k-1];
    end

    // one quotient bit per stage: shift in the next numerator bit, trial subtract
    assign t    = {rem_i, nq_i[NUM_W-1]};
    assign diff = t - {1'b0, den_i};
    assign ge   = (t >= {1'b0, den_i});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
        nq_r[k]  <= {nq_i[NUM_W-2:0], ge};
        den_r[k] <= den_i;
      end
    end
  end

  assign quo = nq_r[DIV_N-1];

endmodule
